// ----- rtl/chunked_write_tick_tracker_unit_assert.svh -----
// Assertion macros used by the top level of the chunked write tick tracker RTL.
// Depends on nothing; included inside module bodies that check themselves.
`ifndef CHUNKED_WRITE_TICK_TRACKER_UNIT_ASSERT_SVH
`define CHUNKED_WRITE_TICK_TRACKER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CWTT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cwtt check failed");

// The consequent must hold in the cycle after the antecedent.
`define CWTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cwtt check failed");

`endif

// ----- rtl/cwtt_pkg.sv -----
// Package of the chunked write tick tracker: sizes, function codes and types.
// Depends on nothing; used by the cell, the top level and the testbench.
package cwtt_pkg;

   localparam int RING_DEPTH = 4;
   localparam int CHUNK_ROWS = 64;
   localparam int MAX_CHUNKS = 64;

   localparam int IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FILL_W  = $clog2(RING_DEPTH + 1);
   localparam int SUM_W   = (RING_DEPTH > 1) ? $clog2(2 * RING_DEPTH) : 1;
   localparam int unsigned ROW_CAP = MAX_CHUNKS * CHUNK_ROWS;

   typedef enum logic [2:0] {
      FN_MARK_ROW = 3'd0,
      FN_MARK_ALL = 3'd1,
      FN_ENSURE   = 3'd2,
      FN_CHUNK_Q  = 3'd3,
      FN_ANY_Q    = 3'd4,
      FN_NEWEST   = 3'd5
   } func_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [11:0] row_index;
      logic [5:0]  chunk_number;
      logic [12:0] entity_total;
      logic [63:0] tick_value;
   } cmd_type;

   typedef struct packed {
      logic row_ge;
      logic row_hit;
      logic total_gt;
      logic chunk_hit;
   } sel_type;

   typedef struct packed {
      logic        tok;
      logic        found;
      logic [63:0] newest;
   } link_type;

   function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
      if (s >= SUM_W'(RING_DEPTH)) begin
         return IDX_W'(s - SUM_W'(RING_DEPTH));
      end
      return IDX_W'(s);
   endfunction

endpackage

// ----- rtl/cwtt_req_if.sv -----
// Request channel of the chunked write tick tracker.
// Depends on nothing beyond the language; carries one command transaction.
interface cwtt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [11:0] row_index;
   logic [5:0]  chunk_number;
   logic [12:0] entity_total;
   logic [63:0] tick_value;

   modport source (output valid, func, row_index, chunk_number, entity_total, tick_value,
                   input ready);
   modport sink (input valid, func, row_index, chunk_number, entity_total, tick_value,
                 output ready);
endinterface

// ----- rtl/cwtt_rsp_if.sv -----
// Response channel of the chunked write tick tracker.
// Depends on nothing beyond the language; carries one result transaction.
interface cwtt_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [63:0] newest_tick;
   logic        error;

   modport source (output valid, found, newest_tick, error, input ready);
   modport sink (input valid, found, newest_tick, error, output ready);
endinterface

// ----- rtl/cwtt_cell.sv -----
// One chunk of the tracker: its ring of stamps, ring pointers and in-use flag.
// Depends on cwtt_pkg; passes the walking token and partial results onwards.
module cwtt_cell (
   input  logic               clock,
   input  logic               reset,
   input  cwtt_pkg::cmd_type  cmd,
   input  cwtt_pkg::sel_type  sel,
   input  cwtt_pkg::link_type link_in,
   output cwtt_pkg::link_type link_out,
   output logic               in_use
);
   import cwtt_pkg::*;

   logic [63:0]       ring_ff [RING_DEPTH];
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              use_ff, use_in;
   link_type          link_ff, link_in_nx;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [IDX_W-1:0]  rd_idx;
   logic [63:0]       newest_val;
   logic              newer;
   logic              do_mark;

   always_comb begin
      rd_idx = ring_wrap(SUM_W'(head_ff) + SUM_W'(fill_ff) - SUM_W'(1));
      newest_val = (fill_ff == '0) ? 64'd0 : ring_ff[rd_idx];
      newer = 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         if ((FILL_W'(i) < fill_ff) &&
             (ring_ff[ring_wrap(SUM_W'(head_ff) + SUM_W'(i))] > cmd.tick_value)) begin
            newer = 1'b1;
         end
      end
   end

   always_comb begin
      head_in    = head_ff;
      fill_in    = fill_ff;
      use_in     = use_ff;
      wr_en      = 1'b0;
      wr_idx     = '0;
      link_in_nx = link_in;
      do_mark    = link_in.tok &&
                   (((cmd.func == FN_MARK_ROW) && sel.row_hit) ||
                    ((cmd.func == FN_MARK_ALL) && use_ff));
      if (link_in.tok) begin
         unique case (cmd.func)
            FN_MARK_ROW: begin
               if (sel.row_ge) begin
                  use_in = 1'b1;
               end
            end
            FN_ENSURE: begin
               if (sel.total_gt) begin
                  use_in = 1'b1;
               end
            end
            FN_CHUNK_Q: begin
               link_in_nx.found = link_in.found | (sel.chunk_hit & use_ff & newer);
            end
            FN_ANY_Q: begin
               link_in_nx.found = link_in.found | (use_ff & newer);
            end
            FN_NEWEST: begin
               if (use_ff && (newest_val > link_in.newest)) begin
                  link_in_nx.newest = newest_val;
               end
            end
            default: begin
            end
         endcase
      end
      if (do_mark) begin
         if (fill_ff == '0) begin
            wr_en   = 1'b1;
            wr_idx  = '0;
            head_in = '0;
            fill_in = FILL_W'(1);
         end else if (newest_val != cmd.tick_value) begin
            wr_en = 1'b1;
            if (fill_ff < FILL_W'(RING_DEPTH)) begin
               wr_idx  = ring_wrap(SUM_W'(head_ff) + SUM_W'(fill_ff));
               fill_in = fill_ff + FILL_W'(1);
            end else begin
               wr_idx  = head_ff;
               head_in = ring_wrap(SUM_W'(head_ff) + SUM_W'(1));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_idx] <= cmd.tick_value;
      end
   end

   always_ff @(posedge clock) begin
      link_ff.found  <= link_in_nx.found;
      link_ff.newest <= link_in_nx.newest;
      if (reset) begin
         head_ff     <= '0;
         fill_ff     <= '0;
         use_ff      <= 1'b0;
         link_ff.tok <= 1'b0;
      end else begin
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         use_ff      <= use_in;
         link_ff.tok <= link_in_nx.tok;
      end
   end

   assign link_out = link_ff;
   assign in_use   = use_ff;

endmodule

// ----- rtl/chunked_write_tick_tracker_unit.sv -----
// Top level of the chunked write tick tracker: control and the row of chunk cells.
// Depends on cwtt_pkg, cwtt_req_if, cwtt_rsp_if, cwtt_cell and the assertion header.
//
//   Channel   Direction  Transaction
//   req_ch    in         one command: func, row, chunk, size, tick
//   rsp_ch    out        one result: found, newest tick, error
//
// A command is taken only when the block is idle, and its token then walks the
// chain of chunk cells one cell per cycle; the result is registered once the
// token leaves the last cell.
// A size beyond capacity answers with an error without walking; a row always fits.
// Reset clears the ring pointers and in-use flags; stamps are kept in cells.
// The result holds until rsp_ch is ready; no new command is taken meanwhile.
module chunked_write_tick_tracker_unit (
   input  logic clock,
   input  logic reset,
   cwtt_req_if.sink   req_ch,
   cwtt_rsp_if.source rsp_ch
);
   import cwtt_pkg::*;

   `include "chunked_write_tick_tracker_unit_assert.svh"

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic        start_ff, start_in;
   logic        found_ff, found_in;
   logic [63:0] newest_ff, newest_in;
   logic        err_ff, err_in;
   logic        req_take;
   logic        cap_err;
   sel_type     sels [MAX_CHUNKS];
   link_type    links [MAX_CHUNKS+1];
   logic [MAX_CHUNKS-1:0] use_vec;
   logic [MAX_CHUNKS-1:0] tok_vec;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign cap_err = ((req_ch.func == FN_MARK_ROW) && (32'(req_ch.row_index) >= ROW_CAP)) ||
                    ((req_ch.func == FN_ENSURE) && (32'(req_ch.entity_total) > ROW_CAP));

   assign links[0] = '{tok: start_ff, found: 1'b0, newest: 64'd0};

   for (genvar c = 0; c < MAX_CHUNKS; c++) begin : g_cell
      localparam int unsigned LO = c * CHUNK_ROWS;
      localparam int unsigned HI = LO + CHUNK_ROWS;
      assign sels[c].row_ge    = 32'(cmd_ff.row_index) >= LO;
      assign sels[c].row_hit   = (32'(cmd_ff.row_index) >= LO) &&
                                 (32'(cmd_ff.row_index) < HI);
      assign sels[c].total_gt  = 32'(cmd_ff.entity_total) > LO;
      assign sels[c].chunk_hit = 32'(cmd_ff.chunk_number) == 32'(c);
      cwtt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd_ff),
         .sel      (sels[c]),
         .link_in  (links[c]),
         .link_out (links[c+1]),
         .in_use   (use_vec[c])
      );
      assign tok_vec[c] = links[c+1].tok;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      start_in  = 1'b0;
      found_in  = found_ff;
      newest_in = newest_ff;
      err_in    = err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in = '{func: req_ch.func, row_index: req_ch.row_index,
                          chunk_number: req_ch.chunk_number,
                          entity_total: req_ch.entity_total,
                          tick_value: req_ch.tick_value};
               if (cap_err) begin
                  found_in  = 1'b0;
                  newest_in = 64'd0;
                  err_in    = 1'b1;
                  state_in  = ST_RESP;
               end else begin
                  start_in = 1'b1;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (links[MAX_CHUNKS].tok) begin
               found_in  = links[MAX_CHUNKS].found;
               newest_in = links[MAX_CHUNKS].newest;
               err_in    = 1'b0;
               state_in  = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      found_ff  <= found_in;
      newest_ff <= newest_in;
      err_ff    <= err_in;
   end

   assign rsp_ch.valid       = (state_ff == ST_RESP);
   assign rsp_ch.found       = found_ff;
   assign rsp_ch.newest_tick = newest_ff;
   assign rsp_ch.error       = err_ff;

   `CWTT_ASSERT_SAME(a_one_token, clock, reset, 1'b1, $onehot0({tok_vec, start_ff}))
   `CWTT_ASSERT_SAME(a_token_walks, clock, reset, (|tok_vec) || start_ff, state_ff == ST_WALK)
   `CWTT_ASSERT_SAME(a_use_prefix, clock, reset, 1'b1,
                     ((use_vec + MAX_CHUNKS'(1)) & use_vec) == '0)
   `CWTT_ASSERT_NEXT(a_rsp_done, clock, reset, rsp_ch.valid && rsp_ch.ready, req_ch.ready)

endmodule

// ----- sim/cwtt_tb_pkg.sv -----
// Scoreboard of the chunked write tick tracker testbench: a model of the rings and
// the queue of expected results. Depends on cwtt_pkg.
package cwtt_tb_pkg;
   import cwtt_pkg::*;

   typedef struct packed {
      logic        found;
      logic [63:0] newest_tick;
      logic        error;
   } result_type;

   class tick_scoreboard;
      logic [63:0] stamps[MAX_CHUNKS][RING_DEPTH];
      int          head[MAX_CHUNKS];
      int          fill[MAX_CHUNKS];
      int          in_use;
      result_type  pending[$];
      int          mismatches;

      function new();
         in_use = 0;
         mismatches = 0;
         foreach (head[c]) begin
            head[c] = 0;
            fill[c] = 0;
         end
      endfunction

      function logic [63:0] newest_of(int c);
         if (fill[c] == 0) begin
            return 64'd0;
         end
         return stamps[c][(head[c] + fill[c] - 1) % RING_DEPTH];
      endfunction

      function void stamp_chunk(int c, logic [63:0] t);
         if (fill[c] == 0) begin
            stamps[c][0] = t;
            head[c] = 0;
            fill[c] = 1;
         end else if (newest_of(c) != t) begin
            if (fill[c] < RING_DEPTH) begin
               stamps[c][(head[c] + fill[c]) % RING_DEPTH] = t;
               fill[c]++;
            end else begin
               stamps[c][head[c]] = t;
               head[c] = (head[c] + 1) % RING_DEPTH;
            end
         end
      endfunction

      function bit holds_newer(int c, logic [63:0] since);
         for (int i = 0; i < fill[c]; i++) begin
            if (stamps[c][(head[c] + i) % RING_DEPTH] > since) begin
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      // Notes an accepted command and queues the result it must produce.
      function void note_command(cmd_type cmd);
         result_type r;
         int         needed;
         int         chunk;
         r = '0;
         case (cmd.func)
            FN_MARK_ROW: begin
               chunk = cmd.row_index / CHUNK_ROWS;
               if (chunk >= MAX_CHUNKS) begin
                  r.error = 1'b1;
               end else begin
                  if (chunk >= in_use) begin
                     in_use = chunk + 1;
                  end
                  stamp_chunk(chunk, cmd.tick_value);
               end
            end
            FN_MARK_ALL: begin
               for (int c = 0; c < in_use; c++) begin
                  stamp_chunk(c, cmd.tick_value);
               end
            end
            FN_ENSURE: begin
               needed = (int'(cmd.entity_total) + CHUNK_ROWS - 1) / CHUNK_ROWS;
               if (needed > MAX_CHUNKS) begin
                  r.error = 1'b1;
               end else if (needed > in_use) begin
                  in_use = needed;
               end
            end
            FN_CHUNK_Q: begin
               if (cmd.chunk_number < in_use) begin
                  r.found = holds_newer(cmd.chunk_number, cmd.tick_value);
               end
            end
            FN_ANY_Q: begin
               for (int c = 0; c < in_use; c++) begin
                  if (holds_newer(c, cmd.tick_value)) begin
                     r.found = 1'b1;
                  end
               end
            end
            FN_NEWEST: begin
               for (int c = 0; c < in_use; c++) begin
                  if (newest_of(c) > r.newest_tick) begin
                     r.newest_tick = newest_of(c);
                  end
               end
            end
            default: begin
            end
         endcase
         pending.push_back(r);
      endfunction

      // Compares one accepted result with the oldest expectation.
      function void check_result(result_type got);
         result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected result transaction: %p", got);
            end
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Result differs: expected %p, actual %p", want, got);
            end
         end
      endfunction
   endclass
endpackage

// ----- sim/tb_top.sv -----
// Top of the chunked write tick tracker testbench: clock, reset, stimulus and
// result checking. Depends on cwtt_pkg, cwtt_tb_pkg, the channel interfaces and the RTL.
module tb_top;
   import cwtt_pkg::*;
   import cwtt_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   logic sending_done = 1'b0;
   int   cycles = 0;
   int   tick_floor;
   tick_scoreboard board;

   cwtt_req_if req_ch ();
   cwtt_rsp_if rsp_ch ();

   chunked_write_tick_tracker_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.func = '0;
      req_ch.row_index = '0;
      req_ch.chunk_number = '0;
      req_ch.entity_total = '0;
      req_ch.tick_value = '0;
      rsp_ch.ready = 1'b0;
      board = new();
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_ch.valid && req_ch.ready) begin
         board.note_command({req_ch.func, req_ch.row_index, req_ch.chunk_number,
                             req_ch.entity_total, req_ch.tick_value});
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_result({rsp_ch.found, rsp_ch.newest_tick, rsp_ch.error});
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= quiet || ($urandom_range(99) >= 26);
      end
   end

   task automatic send(input logic [2:0] fn, input logic [11:0] row, input logic [5:0] chunk,
                       input logic [12:0] total, input logic [63:0] t);
      while (!quiet && $urandom_range(99) < 26) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= fn;
      req_ch.row_index <= row;
      req_ch.chunk_number <= chunk;
      req_ch.entity_total <= total;
      req_ch.tick_value <= t;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      @(negedge clock);
   endtask

   function automatic logic [63:0] near_tick();
      return 64'(tick_floor + $urandom_range(12));
   endfunction

   task automatic random_command();
      int          pick;
      logic [63:0] t;
      pick = $urandom_range(99);
      t = ($urandom_range(19) == 0) ? {$urandom(), $urandom()} : near_tick();
      if (pick < 35) begin
         send(FN_MARK_ROW, ($urandom_range(19) == 0) ? 12'($urandom())
              : 12'($urandom_range(CHUNK_ROWS * 6 - 1)), 6'($urandom()), 13'($urandom()), t);
         tick_floor += $urandom_range(2);
      end else if (pick < 42) begin
         send(FN_MARK_ALL, 12'($urandom()), 6'($urandom()), 13'($urandom()), t);
      end else if (pick < 50) begin
         send(FN_ENSURE, 12'($urandom()), 6'($urandom()),
              ($urandom_range(3) == 0) ? 13'($urandom_range(8191))
              : 13'($urandom_range(CHUNK_ROWS * 8)), t);
      end else if (pick < 72) begin
         send(FN_CHUNK_Q, 12'($urandom()), 6'($urandom_range(9)), 13'($urandom()), t);
      end else if (pick < 86) begin
         send(FN_ANY_Q, 12'($urandom()), 6'($urandom()), 13'($urandom()), t);
      end else if (pick < 97) begin
         send(FN_NEWEST, 12'($urandom()), 6'($urandom()), 13'($urandom()), t);
      end else begin
         send(3'($urandom_range(7, 6)), 12'($urandom()), 6'($urandom()), 13'($urandom()), t);
      end
   endtask

   initial begin
      tick_floor = 100;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(FN_NEWEST, 12'd0, 6'd0, 13'd0, 64'd0);
      send(FN_MARK_ALL, 12'd0, 6'd0, 13'd0, 64'd5);
      send(FN_ANY_Q, 12'hFFF, 6'h3F, 13'h1FFF, 64'd0);
      send(FN_CHUNK_Q, 12'd0, 6'd0, 13'd0, 64'd0);
      send(FN_MARK_ROW, 12'd0, 6'd0, 13'd0, 64'd7);
      send(FN_MARK_ROW, 12'd5, 6'd0, 13'd0, 64'd7);
      send(FN_MARK_ROW, 12'd10, 6'd0, 13'd0, 64'd9);
      send(FN_MARK_ROW, 12'd20, 6'd0, 13'd0, 64'd3);
      send(FN_MARK_ROW, 12'd30, 6'd0, 13'd0, 64'd11);
      send(FN_MARK_ROW, 12'd40, 6'd0, 13'd0, 64'd12);
      send(FN_CHUNK_Q, 12'd0, 6'd0, 13'd0, 64'd7);
      send(FN_MARK_ROW, 12'hFFF, 6'd0, 13'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send(FN_CHUNK_Q, 12'd0, 6'h3F, 13'd0, 64'd0);
      send(FN_ENSURE, 12'd0, 6'd0, 13'd4097, 64'd0);
      send(FN_ENSURE, 12'd0, 6'd0, 13'h1FFF, 64'd0);
      send(FN_ENSURE, 12'd0, 6'd0, 13'd0, 64'd0);
      send(FN_ENSURE, 12'd0, 6'd0, 13'd129, 64'd0);
      send(FN_MARK_ALL, 12'd0, 6'd0, 13'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send(FN_ANY_Q, 12'd0, 6'd0, 13'd0, 64'hFFFF_FFFF_FFFF_FFFE);
      send(FN_NEWEST, 12'd0, 6'd0, 13'd0, 64'd0);
      send(3'd6, 12'hFFF, 6'h3F, 13'h1FFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send(3'd7, 12'd0, 6'd0, 13'd0, 64'd0);
      send(FN_ENSURE, 12'd0, 6'd0, 13'd4096, 64'd0);
      send(FN_NEWEST, 12'd0, 6'd0, 13'd0, 64'd0);

      for (int i = 0; i < 1200; i++) begin
         quiet = (i >= 500 && i < 650);
         random_command();
      end
      req_ch.valid <= 1'b0;
      quiet = 1'b0;
      sending_done = 1'b1;
   end

   initial begin
      wait (sending_done);
      while (board.pending.size() != 0 && cycles < 400000) begin
         @(posedge clock);
      end
      repeat (100) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("chunked_write_tick_tracker_unit: match");
      end else begin
         $display("chunked_write_tick_tracker_unit: mismatch");
      end
      $finish;
   end

   initial begin
      wait (cycles >= 500000);
      $display("chunked_write_tick_tracker_unit: mismatch");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cwtt_pkg.sv
rtl/cwtt_req_if.sv
rtl/cwtt_rsp_if.sv
rtl/cwtt_cell.sv
rtl/chunked_write_tick_tracker_unit.sv
sim/cwtt_tb_pkg.sv
sim/tb_top.sv
